@@ hw/rtl/length_prefixed_frame_receiver_assert.svh @@
// Assertion helpers for the receiver RTL.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

// Clocked check, silenced while reset is held.
`define LPFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define LPFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/lpfr_pkg.sv @@
package lpfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int WP_W         = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_W        = 16;
    localparam int HEADER_LAST  = 3;
    localparam int HEADER_LOW   = 2;
    localparam int BYTE_W       = 8;

    localparam int          PADDR_W          = 3;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd40;

    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0,
        REG_NONE    = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RX_IDLE      = 2'd0,
        RX_RECEIVING = 2'd1,
        RX_READY     = 2'd2
    } rx_state_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  rx_byte;
        logic [5:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  rx_state;
        logic [6:0]  byte_count;
        logic [15:0] payload_length;
        logic        frame_complete;
        logic        overflow;
        logic        timed_out;
        logic [7:0]  read_data;
    } out_item_t;

endpackage

@@ hw/rtl/length_prefixed_frame_receiver.sv @@
// Length-prefixed frame receiver.
// The s_ channel carries one command per beat: a received byte, a timer tick,
// a release of the held frame, or a read of a stored byte. Every input beat
// yields exactly one result beat on the m_ channel with the state after the
// command, the byte count, the latched payload length, the event flags and,
// for reads, the stored byte.
// m_valid rises the cycle after a beat is accepted; one beat is taken every
// cycle unless m_ stalls. The command is decoded and the state updated in the
// cycle it is accepted; the frame store read port and the result register
// are loaded on the same edge, so both appear together on the next cycle.
// When the m_ side stalls, the held result stays put and s_ready drops until
// it is taken; s_ready is high whenever the result register is empty or
// being emptied.
// The APB port holds timeout_ticks at address 0, loaded into the inactivity
// countdown by each byte that opens or continues a frame.
// Reset puts the receiver idle with zero count, length and countdown and
// restores timeout_ticks to 40. The frame store is not cleared; only bytes
// written in the latest frame are ever read back.
module length_prefixed_frame_receiver
    import lpfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "length_prefixed_frame_receiver_assert.svh"

    rx_state_t         state_reg, state_next, st_eff;
    logic [WP_W-1:0]   wp_reg, wp_next, wp_eff;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [15:0]       count_reg, count_next;
    logic [15:0]       timeout_reg;
    logic [7:0]        hdr_low_reg, hdr_low_next;

    logic              m_valid_reg;
    out_item_t         out_reg, out_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [7:0]        ram_q_reg;
    logic [7:0]        frame_mem [BUFFER_DEPTH];

    logic              s_fire;
    logic              wp_fits, len_hit;
    logic              mem_we;
    logic              done, ovf, tmo;
    reg_index_t        reg_index;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign pready  = 1'b1;
    assign m_valid = m_valid_reg;

    // ---------------- configuration ----------------
    assign reg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_index)
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // ---------------- byte decode ----------------
    // A byte seen while idle opens a new frame at position zero.
    assign st_eff  = (state_reg == RX_IDLE) ? RX_RECEIVING : state_reg;
    assign wp_eff  = (state_reg == RX_IDLE) ? '0 : wp_reg;
    assign wp_fits = wp_eff < WP_W'(BUFFER_DEPTH);
    assign len_hit = (wp_eff > WP_W'(HEADER_LAST)) &&
                     (LEN_W'(wp_eff - WP_W'(HEADER_LAST)) == len_reg);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        if (s_fire) begin
            unique case (s_data.command)
                CMD_BYTE: begin
                    if (st_eff == RX_RECEIVING) begin
                        if (!wp_fits) begin
                            state_next = RX_IDLE;
                        end else if (len_hit) begin
                            state_next = RX_READY;
                        end else begin
                            state_next = RX_RECEIVING;
                        end
                    end
                end
                CMD_TICK: begin
                    if (count_reg == '0 && state_reg == RX_RECEIVING) begin
                        state_next = RX_IDLE;
                    end
                end
                CMD_RELEASE: state_next = RX_IDLE;
                CMD_READ:    state_next = state_reg;
                default:     state_next = state_reg;
            endcase
        end
    end

    // ---------------- datapath and flags ----------------
    always_comb begin
        wp_next      = wp_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        hdr_low_next = hdr_low_reg;
        mem_we       = 1'b0;
        done         = 1'b0;
        ovf          = 1'b0;
        tmo          = 1'b0;
        rd_ok_next   = 1'b0;
        if (s_fire) begin
            unique case (s_data.command)
                CMD_BYTE: begin
                    if (st_eff == RX_RECEIVING) begin
                        wp_next    = wp_eff;
                        count_next = timeout_reg;
                        if (wp_fits) begin
                            mem_we  = 1'b1;
                            wp_next = wp_eff + 1'b1;
                            done    = len_hit;
                            if (wp_eff == WP_W'(HEADER_LOW)) begin
                                hdr_low_next = s_data.rx_byte;
                            end
                            if (wp_eff == WP_W'(HEADER_LAST)) begin
                                len_next = {s_data.rx_byte, hdr_low_reg};
                            end
                        end else begin
                            ovf = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end else if (state_reg == RX_RECEIVING) begin
                        tmo = 1'b1;
                    end
                end
                CMD_READ:    rd_ok_next = WP_W'(s_data.read_index) < wp_reg;
                CMD_RELEASE: ;
                default:     ;
            endcase
        end
    end

    always_comb begin
        out_next.rx_state       = state_next;
        out_next.byte_count     = wp_next;
        out_next.payload_length = len_next;
        out_next.frame_complete = done;
        out_next.overflow       = ovf;
        out_next.timed_out      = tmo;
        out_next.read_data      = '0;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= RX_IDLE;
            wp_reg      <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result while the m_ side stalls.
    always_ff @(posedge aclk) begin
        hdr_low_reg <= hdr_low_next;
        if (s_fire) begin
            out_reg   <= out_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    // ---------------- frame store ----------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[wp_eff[ADDR_W-1:0]] <= s_data.rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ram_q_reg <= frame_mem[s_data.read_index];
        end
    end

    always_comb begin
        m_data           = out_reg;
        m_data.read_data = rd_ok_reg ? ram_q_reg : 8'd0;
    end

    // ---------------- checks ----------------
    `LPFR_ASSERT(a_fire_gives_result, s_fire |=> m_valid_reg,
                 "accepted beat left no result")
    `LPFR_ASSERT(a_release_idles,
                 s_fire && s_data.command == CMD_RELEASE |=> state_reg == RX_IDLE,
                 "release did not idle")
    `LPFR_ASSERT(a_ready_ignores_bytes,
                 s_fire && s_data.command == CMD_BYTE && state_reg == RX_READY |=>
                 state_reg == RX_READY && $stable(wp_reg),
                 "byte altered a held frame")
    `LPFR_ASSERT(a_one_flag,
                 m_valid_reg |->
                 $countones({out_reg.frame_complete, out_reg.overflow,
                             out_reg.timed_out}) <= 1,
                 "more than one event flag")
    `LPFR_ASSERT(a_wp_bound, wp_reg <= WP_W'(BUFFER_DEPTH),
                 "write position past the store")

endmodule

@@ test/tb_length_prefixed_frame_receiver.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_frame_receiver;
    import lpfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_REPORTS  = 10;

    // Mirrors the receiver: state, countdown and frame store, one expected beat per input.
    class frame_rx_scoreboard;
        logic [15:0] timeout_ticks;
        rx_state_t   rx_st;
        logic [6:0]  wr_pos;
        logic [15:0] len_field;
        logic [15:0] countdown;
        logic [7:0]  store [BUFFER_DEPTH];
        out_item_t   expected_q [$];
        int mismatches;
        int checked;
        int frames_done;
        int overflows;
        int timeouts;
        int reads;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            rx_st         = RX_IDLE;
            wr_pos        = '0;
            len_field     = '0;
            countdown     = '0;
            mismatches    = 0;
            checked       = 0;
            frames_done   = 0;
            overflows     = 0;
            timeouts      = 0;
            reads         = 0;
        endfunction

        function void set_timeout(logic [15:0] v);
            timeout_ticks = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(in_item_t it);
            out_item_t exp_beat;
            exp_beat = '0;
            case (it.command)
                CMD_BYTE: begin
                    if (rx_st == RX_IDLE) begin
                        wr_pos = '0;
                        rx_st  = RX_RECEIVING;
                    end
                    if (rx_st == RX_RECEIVING) begin
                        countdown = timeout_ticks;
                        if (wr_pos < BUFFER_DEPTH) begin
                            store[wr_pos[ADDR_W-1:0]] = it.rx_byte;
                            if (wr_pos == HEADER_LAST)
                                len_field = {store[HEADER_LAST], store[HEADER_LOW]};
                            if (wr_pos > HEADER_LAST && (wr_pos - HEADER_LAST) == len_field) begin
                                rx_st = RX_READY;
                                exp_beat.frame_complete = 1'b1;
                                frames_done++;
                            end
                            wr_pos = wr_pos + 7'd1;
                        end else begin
                            // store full: drop the frame, keep the position
                            rx_st = RX_IDLE;
                            exp_beat.overflow = 1'b1;
                            overflows++;
                        end
                    end
                end
                CMD_TICK: begin
                    if (countdown != 0) begin
                        countdown = countdown - 16'd1;
                    end else if (rx_st == RX_RECEIVING) begin
                        rx_st = RX_IDLE;
                        exp_beat.timed_out = 1'b1;
                        timeouts++;
                    end
                end
                CMD_RELEASE: begin
                    rx_st = RX_IDLE;
                end
                default: begin
                    reads++;
                    if (it.read_index < wr_pos)
                        exp_beat.read_data = store[it.read_index];
                end
            endcase
            exp_beat.rx_state       = rx_st;
            exp_beat.byte_count     = wr_pos;
            exp_beat.payload_length = len_field;
            expected_q.push_back(exp_beat);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: %p", got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.rx_state !== want.rx_state || got.byte_count !== want.byte_count ||
                got.payload_length !== want.payload_length ||
                got.frame_complete !== want.frame_complete ||
                got.overflow !== want.overflow || got.timed_out !== want.timed_out ||
                got.read_data !== want.read_data) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("beat %0d mismatch: expected st=%0d cnt=%0d len=%0d done=%0b ovf=%0b tmo=%0b rd=%02h, actual st=%0d cnt=%0d len=%0d done=%0b ovf=%0b tmo=%0b rd=%02h",
                             checked, want.rx_state, want.byte_count, want.payload_length,
                             want.frame_complete, want.overflow, want.timed_out,
                             want.read_data, got.rx_state, got.byte_count,
                             got.payload_length, got.frame_complete, got.overflow,
                             got.timed_out, got.read_data);
            end
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b1;
    out_item_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    frame_rx_scoreboard sb = new();
    bit          idling_on   = 1'b0;
    int          sent_items  = 0;
    int          cycle_count = 0;
    int          reg_errors  = 0;
    int          settings    = 0;
    logic [15:0] cur_timeout = TIMEOUT_RESET;

    length_prefixed_frame_receiver DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Result side: random stall bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(cmd_t cmd, logic [7:0] b, logic [5:0] idx);
        in_item_t it;
        it.command    = cmd;
        it.rx_byte    = b;
        it.read_index = idx;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        sent_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(CMD_BYTE, b, 6'($urandom));
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom), 6'($urandom));
    endtask

    task automatic send_release();
        send_item(CMD_RELEASE, 8'($urandom), 6'($urandom));
    endtask

    task automatic send_read(logic [5:0] idx);
        send_item(CMD_READ, 8'($urandom), idx);
    endtask

    // Hold the sender until every result beat is back.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TIMEOUT, 2'b00};
        pwdata  <= {16'h0000, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'h0000, v}) begin
            reg_errors++;
            $display("timeout_ticks readback: expected %0d, actual %0d", v, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_timeout(v);
        cur_timeout = v;
        settings++;
    endtask

    // Header with the given length, then payload until done or one byte past full.
    task automatic send_frame(logic [15:0] len, bit with_ticks);
        int total;
        total = (len >= 1 && len <= BUFFER_DEPTH - 4) ? 4 + len : BUFFER_DEPTH + 1;
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 4; i < total; i++) begin
            if (with_ticks && $urandom_range(0, 4) == 0)
                send_tick();
            send_byte(8'($urandom));
        end
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) == 0)
                send_read(6'($urandom));
            else
                send_read(6'($urandom_range(0, (total + 1 > 63) ? 63 : total + 1)));
        end
        if ($urandom_range(0, 1) == 0)
            send_byte(8'($urandom));
        if ($urandom_range(0, 9) != 0)
            send_release();
    endtask

    task automatic send_stalled_frame();
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        if (cur_timeout <= 10) begin
            repeat ($urandom_range(cur_timeout, cur_timeout + 2)) send_tick();
        end else begin
            repeat ($urandom_range(1, 4)) send_tick();
            send_release();
        end
    endtask

    task automatic run_random(int n_items, bit allow_idle);
        int start;
        int pick;
        start = sent_items;
        while (sent_items - start < n_items) begin
            idling_on = allow_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick <= 10)
                send_frame(16'($urandom_range(1, 8)), cur_timeout >= 4 && $urandom_range(0, 1));
            else if (pick == 11)
                send_frame(16'($urandom_range(1, BUFFER_DEPTH - 4)), 1'b0);
            else if (pick == 12)
                send_frame(($urandom_range(0, 1) == 0) ? 16'd0 :
                           16'($urandom_range(BUFFER_DEPTH - 3, 65535)), 1'b0);
            else if (pick <= 15)
                send_stalled_frame();
            else
                repeat ($urandom_range(1, 6))
                    send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of the countdown, a full frame and the ready state
        send_read(6'd0);
        send_tick();
        send_release();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h12);
        send_read(6'd5);
        send_read(6'd63);
        send_read(6'd4);
        send_release();
        send_read(6'd2);
        send_byte(8'h7E);
        send_release();
        drain();

        // zero countdown: the first tick of a frame abandons it
        write_timeout(16'd0);
        send_byte(8'h3C);
        send_tick();
        send_tick();
        send_byte(8'hC3);
        send_release();
        send_tick();
        drain();

        run_random(PHASE_ITEMS, 1'b1);
        write_timeout(16'd3);
        run_random(PHASE_ITEMS, 1'b1);
        write_timeout(16'hFFFF);
        run_random(PHASE_ITEMS, 1'b1);
        write_timeout(16'($urandom_range(1, 8)));
        run_random(PHASE_ITEMS, 1'b1);
        write_timeout(16'd2);
        run_random(PHASE_ITEMS, 1'b0);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("%0d beats sent, %0d results checked, %0d timeout settings written",
                 sent_items, sb.checked, settings);
        $display("%0d frames completed, %0d overflows, %0d timeouts, %0d reads",
                 sb.frames_done, sb.overflows, sb.timeouts, sb.reads);
        if (sb.mismatches == 0 && reg_errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", sb.mismatches + reg_errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
